>>> design/cv3c_pkg.sv
`default_nettype none

package cv3c_pkg;

	localparam int MAX_WIDTH      = 1024;
	localparam int LB_AW          = $clog2(MAX_WIDTH);
	localparam int KERNEL_SIZE    = 3;
	localparam int COEF_FRAC_BITS = 8;

	localparam int PIX_W   = 8;
	localparam int DIM_W   = 11;
	localparam int ROW_W   = DIM_W + 1;
	localparam int CNT_W   = 21;
	localparam int AREA_W  = 2 * DIM_W;
	localparam int COEF_W  = 16;
	localparam int CFG_W   = KERNEL_SIZE * COEF_W;
	localparam int PROD_W  = PIX_W + COEF_W;
	localparam int CSUM_W  = PROD_W + 2;
	localparam int ACC_W   = CSUM_W + 2;
	localparam int REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_COEF_ROW0    = 3'd2,
		REG_COEF_ROW1    = 3'd3,
		REG_COEF_ROW2    = 3'd4
	} cfg_reg_t;

	// index 0 is the top kernel row
	typedef logic [KERNEL_SIZE-1:0][PIX_W-1:0]  pix_col_t;
	typedef logic [KERNEL_SIZE-1:0][COEF_W-1:0] coef_col_t;

	typedef struct packed {
		logic shift;
		logic ld_prod;
		logic ld_sum;
		logic mask_top;
		logic mask_bot;
	} cell_ctl_t;

endpackage

`default_nettype wire

>>> design/cv3c_linebuf.sv
`default_nettype none

module cv3c_linebuf import cv3c_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [LB_AW-1:0] rd_addr,
	input  logic             wr_en,
	input  logic [LB_AW-1:0] wr_addr,
	input  logic [PIX_W-1:0] wr_above,
	input  logic [PIX_W-1:0] wr_two,
	output logic [PIX_W-1:0] above,
	output logic [PIX_W-1:0] two_above,
	output logic             busy
);

	logic [PIX_W-1:0] mem_above [MAX_WIDTH];
	logic [PIX_W-1:0] mem_two   [MAX_WIDTH];

	logic [PIX_W-1:0] rd_above_q;
	logic [PIX_W-1:0] rd_two_q;
	logic [PIX_W-1:0] fwd_above_q;
	logic [PIX_W-1:0] fwd_two_q;
	logic             fwd_q;
	logic             busy_q;
	logic [LB_AW-1:0] clr_addr_q;

	logic             we;
	logic [LB_AW-1:0] waddr;
	logic [PIX_W-1:0] wd_above;
	logic [PIX_W-1:0] wd_two;

	assign we       = busy_q || wr_en;
	assign waddr    = busy_q ? clr_addr_q : wr_addr;
	assign wd_above = busy_q ? '0 : wr_above;
	assign wd_two   = busy_q ? '0 : wr_two;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_above[waddr] <= wd_above;
			mem_two[waddr]   <= wd_two;
		end
		if (rd_en) begin
			rd_above_q  <= mem_above[rd_addr];
			rd_two_q    <= mem_two[rd_addr];
			fwd_above_q <= wr_above;
			fwd_two_q   <= wr_two;
		end
	end

	// a read that meets a write to the same entry takes the new word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	// zero both lines once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + LB_AW'(1);
			if (clr_addr_q == LB_AW'(MAX_WIDTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign above     = fwd_q ? fwd_above_q : rd_above_q;
	assign two_above = fwd_q ? fwd_two_q   : rd_two_q;
	assign busy      = busy_q;

endmodule

`default_nettype wire

>>> design/cv3c_cell.sv
`default_nettype none

module cv3c_cell import cv3c_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_ctl_t                ctl,
	input  logic                     mask_col,
	input  pix_col_t                 col_in,
	input  coef_col_t                coef,
	output pix_col_t                 col_out,
	output logic signed [CSUM_W-1:0] sum
);

	pix_col_t                        pix_q;
	logic signed [PROD_W:0]          prod_full [KERNEL_SIZE];
	logic signed [PROD_W-1:0]        prod_s3   [KERNEL_SIZE];
	logic signed [CSUM_W-1:0]        sum_s4;
	logic        [KERNEL_SIZE-1:0]   row_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
		end else if (ctl.shift) begin
			pix_q <= col_in;
		end
	end

	assign row_mask = {ctl.mask_bot, 1'b0, ctl.mask_top};

	always_comb begin
		for (int r = 0; r < KERNEL_SIZE; r++) begin
			prod_full[r] = $signed({1'b0, pix_q[r]}) * $signed(coef[r]);
		end
	end

	// drop taps that fall outside the image
	always_ff @(posedge clk) begin
		if (ctl.ld_prod) begin
			for (int r = 0; r < KERNEL_SIZE; r++) begin
				prod_s3[r] <= (row_mask[r] || mask_col) ? '0 : prod_full[r][PROD_W-1:0];
			end
		end
		if (ctl.ld_sum) begin
			sum_s4 <= CSUM_W'(prod_s3[0]) + CSUM_W'(prod_s3[1]) + CSUM_W'(prod_s3[2]);
		end
	end

	assign col_out = pix_q;
	assign sum     = sum_s4;

endmodule

`default_nettype wire

>>> design/conv2d_3x3_clamped_top.sv
// 3x3 convolution over a raster stream of 8-bit pixels, zero padded at the
// image borders, result truncated to an integer and clamped to 0..255.
// Input channel: in_valid / in_stall with in_pixel and drain. After every
// frame the source sends image_width+1 words with drain set to flush the last
// row; a drain word counts as a zero pixel.
// Output channel: out_valid / out_stall with out_pixel, row_end, frame_end.
// Each output pixel is completed by the input word image_width+1 positions
// after its own pixel; the word then moves via the window, product and sum
// registers to the output register. One word per cycle while in_stall is
// low, set by the line buffer (one read, one write port) and the three cells.
// Configuration: cfg_valid / cfg_ready (always ready) with cfg_index and
// cfg_data; write only while no word is in flight.
// Reset: counters, window and pipeline clear at once; the two line buffers
// are then zeroed over all 1024 entries, during which in_stall stays high.
// A stall on a valid output holds the output register; the stall ripples back
// through full stages only, so bubbles inside the pipe still fill.
`default_nettype none

module conv2d_3x3_clamped_top import cv3c_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [PIX_W-1:0]     in_pixel,
	input  logic                 drain,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [PIX_W-1:0]     out_pixel,
	output logic                 row_end,
	output logic                 frame_end,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// configuration
	logic [DIM_W-1:0] cfg_width_q;
	logic [DIM_W-1:0] cfg_height_q;
	logic [CFG_W-1:0] coef_row0_q;
	logic [CFG_W-1:0] coef_row1_q;
	logic [CFG_W-1:0] coef_row2_q;

	// position
	logic [LB_AW-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [CNT_W-1:0] cnt_q;

	logic              accept;
	logic [DIM_W-1:0]  w_eff;
	logic [DIM_W-1:0]  h_eff;
	logic              wrap_pre;
	logic [LB_AW-1:0]  col_cur;
	logic [ROW_W-1:0]  row_cur;
	logic [ROW_W-1:0]  row_inc;
	logic              produce;
	logic [DIM_W-1:0]  ocol;
	logic [ROW_W-1:0]  orow;
	logic [AREA_W-1:0] area;
	logic [AREA_W-1:0] cnt_inc;
	logic              last_cur;
	logic [DIM_W-1:0]  col_nx;
	logic              wrap_nx;

	// pipeline
	logic             v1_q, v2_q, v3_q, v4_q, out_valid_q;
	logic             hold1, hold2, hold3, hold4, hold_o;
	logic [PIX_W-1:0] pix_s1;
	logic [LB_AW-1:0] col_s1;
	logic             produce_s1, mtop_s1, mbot_s1, mleft_s1, mright_s1, last_s1;
	logic             mtop_s2, mbot_s2, mleft_s2, mright_s2, last_s2;
	logic             rend_s3, last_s3, rend_s4, last_s4;
	logic [PIX_W-1:0] out_pixel_q;
	logic             row_end_q, frame_end_q;

	logic             lb_busy;
	logic             lb_wr;
	logic [PIX_W-1:0] la, lt;

	cell_ctl_t                ctl;
	pix_col_t                 col_new, link21, link10;
	coef_col_t                coef_c0, coef_c1, coef_c2;
	logic signed [CSUM_W-1:0] csum0, csum1, csum2;
	logic signed [ACC_W-1:0]  acc;
	logic [PIX_W-1:0]         pix_clamp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= DIM_W'(1024);
			cfg_height_q <= DIM_W'(1024);
			coef_row0_q  <= '0;
			coef_row1_q  <= CFG_W'(48'h0000_0100_0000);
			coef_row2_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  cfg_width_q  <= cfg_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT: cfg_height_q <= cfg_data[DIM_W-1:0];
				REG_COEF_ROW0:    coef_row0_q  <= cfg_data;
				REG_COEF_ROW1:    coef_row1_q  <= cfg_data;
				REG_COEF_ROW2:    coef_row2_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// stall chain: a stage holds only when it is full and the next one holds
	assign hold_o   = out_valid_q && out_stall;
	assign hold4    = v4_q && hold_o;
	assign hold3    = v3_q && hold4;
	assign hold2    = v2_q && hold3;
	assign hold1    = v1_q && hold2;
	assign in_stall = hold1 || lb_busy;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		if (cfg_width_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (cfg_width_q > DIM_W'(MAX_WIDTH)) begin
			w_eff = DIM_W'(MAX_WIDTH);
		end else begin
			w_eff = cfg_width_q;
		end
		h_eff = (cfg_height_q == '0) ? DIM_W'(1) : cfg_height_q;

		// a column left past a narrower width wraps first
		wrap_pre = DIM_W'(col_q) >= w_eff;
		col_cur  = wrap_pre ? '0 : col_q;
		row_cur  = wrap_pre ? row_q + ROW_W'(1) : row_q;
		row_inc  = row_cur + ROW_W'(1);

		produce = (row_cur >= ROW_W'(2)) || (row_cur == ROW_W'(1) && col_cur != '0);
		if (col_cur == '0) begin
			ocol = w_eff - DIM_W'(1);
			orow = row_cur - ROW_W'(2);
		end else begin
			ocol = DIM_W'(col_cur) - DIM_W'(1);
			orow = row_cur - ROW_W'(1);
		end

		area     = AREA_W'(w_eff) * AREA_W'(h_eff);
		cnt_inc  = AREA_W'(cnt_q) + AREA_W'(1);
		last_cur = produce && (cnt_inc >= area);
		col_nx   = DIM_W'(col_cur) + DIM_W'(1);
		wrap_nx  = col_nx >= w_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (last_cur) begin
				col_q <= '0;
				row_q <= '0;
				cnt_q <= '0;
			end else begin
				if (produce) begin
					cnt_q <= cnt_inc[CNT_W-1:0];
				end
				if (wrap_nx) begin
					col_q <= '0;
					row_q <= ROW_W'(row_inc[DIM_W-1:0]);
				end else begin
					col_q <= col_nx[LB_AW-1:0];
					row_q <= row_cur;
				end
			end
		end
	end

	// stage 1: line buffer read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (!hold1) begin
			v1_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1     <= drain ? '0 : in_pixel;
			col_s1     <= col_cur;
			produce_s1 <= produce;
			mtop_s1    <= orow == '0;
			mbot_s1    <= orow >= ROW_W'(h_eff - DIM_W'(1));
			mleft_s1   <= ocol == '0;
			mright_s1  <= ocol >= (w_eff - DIM_W'(1));
			last_s1    <= last_cur;
		end
	end

	assign lb_wr = v1_q && !hold2;

	cv3c_linebuf u_linebuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr   (col_cur),
		.wr_en     (lb_wr),
		.wr_addr   (col_s1),
		.wr_above  (pix_s1),
		.wr_two    (la),
		.above     (la),
		.two_above (lt),
		.busy      (lb_busy)
	);

	// stage 2 lives in the window cells; stages 3 and 4 in their products and sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			v4_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!hold2) begin
				v2_q <= v1_q && produce_s1;
			end
			if (!hold3) begin
				v3_q <= v2_q;
			end
			if (!hold4) begin
				v4_q <= v3_q;
			end
			if (!hold_o) begin
				out_valid_q <= v4_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!hold2) begin
			mtop_s2   <= mtop_s1;
			mbot_s2   <= mbot_s1;
			mleft_s2  <= mleft_s1;
			mright_s2 <= mright_s1;
			last_s2   <= last_s1;
		end
		if (!hold3) begin
			rend_s3 <= mright_s2;
			last_s3 <= last_s2;
		end
		if (!hold4) begin
			rend_s4 <= rend_s3;
			last_s4 <= last_s3;
		end
		if (!hold_o) begin
			out_pixel_q <= pix_clamp;
			row_end_q   <= rend_s4;
			frame_end_q <= last_s4;
		end
	end

	assign ctl.shift    = lb_wr;
	assign ctl.ld_prod  = !hold3;
	assign ctl.ld_sum   = !hold4;
	assign ctl.mask_top = mtop_s2;
	assign ctl.mask_bot = mbot_s2;

	assign col_new = {pix_s1, la, lt};
	assign coef_c0 = {coef_row2_q[0*COEF_W +: COEF_W], coef_row1_q[0*COEF_W +: COEF_W],
		coef_row0_q[0*COEF_W +: COEF_W]};
	assign coef_c1 = {coef_row2_q[1*COEF_W +: COEF_W], coef_row1_q[1*COEF_W +: COEF_W],
		coef_row0_q[1*COEF_W +: COEF_W]};
	assign coef_c2 = {coef_row2_q[2*COEF_W +: COEF_W], coef_row1_q[2*COEF_W +: COEF_W],
		coef_row0_q[2*COEF_W +: COEF_W]};

	// new column enters on the right and moves left one cell per word
	cv3c_cell u_cell2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.mask_col (mright_s2),
		.col_in   (col_new),
		.coef     (coef_c2),
		.col_out  (link21),
		.sum      (csum2)
	);

	cv3c_cell u_cell1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.mask_col (1'b0),
		.col_in   (link21),
		.coef     (coef_c1),
		.col_out  (link10),
		.sum      (csum1)
	);

	cv3c_cell u_cell0 (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.mask_col (mleft_s2),
		.col_in   (link10),
		.coef     (coef_c0),
		.col_out  (),
		.sum      (csum0)
	);

	always_comb begin
		acc = ACC_W'(csum0) + ACC_W'(csum1) + ACC_W'(csum2);
		if (acc[ACC_W-1]) begin
			pix_clamp = '0;
		end else if (|acc[ACC_W-2:COEF_FRAC_BITS+PIX_W]) begin
			pix_clamp = '1;
		end else begin
			pix_clamp = acc[COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = out_pixel_q;
	assign row_end   = row_end_q;
	assign frame_end = frame_end_q;

	a_full_pipe_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q && v2_q && v3_q && v4_q && out_valid_q && out_stall |-> in_stall)
		else $error("full pipeline took a word under output stall");

	a_idle_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		lb_busy |-> !v1_q && !v2_q)
		else $error("word in flight while line buffers clear");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		$past(accept && last_cur) |-> col_q == '0 && row_q == '0 && cnt_q == '0)
		else $error("position not cleared after frame end");

endmodule

`default_nettype wire
